FILE: rtl/grg_pkg.sv
// Shared types, constants and glyph font functions for the glyph rectangle generator.
`timescale 1ns / 1ps
package grg_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int CELL_COUNT = GLYPH_ROWS * GLYPH_COLS;

  localparam logic [2:0] COL_LAST  = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] ROW_LAST  = 3'(GLYPH_ROWS - 1);
  localparam logic [5:0] CELL_TOP  = 6'(CELL_COUNT - 1);
  localparam logic [5:0] CELL_NONE = 6'h3F;

  localparam logic REG_PIXEL_SIZE     = 1'b0;
  localparam logic REG_LETTER_SPACING = 1'b1;

  typedef logic [CELL_COUNT-1:0] glyph_cells_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } grg_rect_t;

  // Row 0 in the top bits, leftmost column first.
  function automatic glyph_cells_t glyph_cells(input logic [7:0] code);
    glyph_cells_t cells;
    case (code)
      "S":     cells = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
      "T":     cells = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "A":     cells = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "R":     cells = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "O":     cells = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P":     cells = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "I":     cells = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "N":     cells = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "G":     cells = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "Q":     cells = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      "U":     cells = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      default: cells = '0;
    endcase
    return cells;
  endfunction

  // Index (row*5+col) of the final lit cell.
  function automatic logic [5:0] glyph_last_cell(input logic [7:0] code);
    logic [5:0] idx;
    case (code)
      "S", "O", "I", "G", "U": idx = 6'd33;
      "T":                     idx = 6'd32;
      "A", "R", "N", "Q":      idx = 6'd34;
      "P":                     idx = 6'd30;
      default:                 idx = CELL_NONE;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/glyph_rectangle_generator_core.sv
// Top level of the glyph rectangle generator: config registers, sequencer and output register.
//
// Input channel in_*: one item per character. in_tdata holds the character code,
// start x and start y; in_tuser is the new-word flag, which loads the start
// position before drawing. Output channel out_*: one item per lit cell of the
// 5x7 glyph, the top-left corner of a square; out_tlast marks the final square
// of a character. Unknown characters give no items but still move the cursor.
// Sequence: an item is taken in the idle state, then the scan state steps through
// the 35 glyph cells (one cell per cycle through a single shared adder while the
// receiver does not stall) and the advance state adds the letter spacing to the cursor.
// Each lit cell's square is registered in the output register before it leaves.
// When the receiver stalls, the scan holds on a lit cell until the output
// register frees; in_tready stays low until the character is finished.
// Reset: cursor and line y to zero, pixel size and letter spacing to one.
// Config writes (cfg_we, cfg_addr 0 = pixel size, 1 = spacing) take effect at
// once and are to be made only while the block is idle.
`timescale 1ns / 1ps
module glyph_rectangle_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // char_code[7:0], start_x[23:8], start_y[39:24]
  input  logic        in_tuser,   // new_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // rect_x[15:0], rect_y[31:16]
  output logic        out_tlast   // last_of_char
);

  logic [5:0]          pixel_size_r;
  logic [7:0]          letter_spacing_r;
  logic                out_valid_r;
  logic [31:0]         out_data_r;
  logic                out_last_r;
  logic                slot_free;
  logic                seq_idle;
  grg_pkg::grg_rect_t  rect;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = seq_idle;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  grg_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_tvalid && seq_idle),
    .char_code      (in_tdata[7:0]),
    .new_word       (in_tuser),
    .start_x        (in_tdata[23:8]),
    .start_y        (in_tdata[39:24]),
    .pixel_size     (pixel_size_r),
    .letter_spacing (letter_spacing_r),
    .slot_free      (slot_free),
    .idle           (seq_idle),
    .rect           (rect)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_size_r     <= 6'd1;
      letter_spacing_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        grg_pkg::REG_PIXEL_SIZE:     pixel_size_r     <= cfg_wdata[5:0];
        grg_pkg::REG_LETTER_SPACING: letter_spacing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rect.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rect.valid) begin
      out_data_r <= {rect.y, rect.x};
      out_last_r <= rect.last;
    end
  end

endmodule

FILE: rtl/grg_seq.sv
// Cell scan sequencer with one shared 16-bit adder for coordinates and cursor.
`timescale 1ns / 1ps
module grg_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [7:0]           char_code,
  input  logic                 new_word,
  input  logic [15:0]          start_x,
  input  logic [15:0]          start_y,
  input  logic [5:0]           pixel_size,
  input  logic [7:0]           letter_spacing,
  input  logic                 slot_free,
  output logic                 idle,
  output grg_pkg::grg_rect_t   rect
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [15:0]                 cursor_r, cursor_nxt;
  logic [15:0]                 row_y_r, row_y_nxt;
  logic [15:0]                 x_acc_r, x_acc_nxt;
  logic [15:0]                 y_acc_r, y_acc_nxt;
  logic [2:0]                  col_r, col_nxt;
  logic [2:0]                  row_r, row_nxt;
  logic [5:0]                  cell_r, cell_nxt;
  logic [5:0]                  last_r, last_nxt;
  grg_pkg::glyph_cells_t       cells_r, cells_nxt;

  logic                        lit;
  logic                        hold;
  logic                        row_wrap;
  logic [15:0]                 add_a, add_b, sum;

  assign lit      = cells_r[grg_pkg::CELL_TOP - cell_r];
  assign hold     = lit && !slot_free;
  assign row_wrap = (col_r == grg_pkg::COL_LAST) && (row_r != grg_pkg::ROW_LAST);
  assign idle     = (state_r == ST_IDLE);

  assign add_a = (state_r == ST_SCAN && row_wrap) ? y_acc_r : x_acc_r;
  assign add_b = (state_r == ST_ADV) ? {8'b0, letter_spacing} : {10'b0, pixel_size};
  assign sum   = add_a + add_b;

  always_comb begin
    rect.valid = (state_r == ST_SCAN) && lit && slot_free;
    rect.x     = x_acc_r;
    rect.y     = y_acc_r;
    rect.last  = (cell_r == last_r);
  end

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    row_y_nxt  = row_y_r;
    x_acc_nxt  = x_acc_r;
    y_acc_nxt  = y_acc_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cell_nxt   = cell_r;
    last_nxt   = last_r;
    cells_nxt  = cells_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (new_word) begin
            cursor_nxt = start_x;
            row_y_nxt  = start_y;
            x_acc_nxt  = start_x;
            y_acc_nxt  = start_y;
          end else begin
            x_acc_nxt = cursor_r;
            y_acc_nxt = row_y_r;
          end
          col_nxt   = '0;
          row_nxt   = '0;
          cell_nxt  = '0;
          cells_nxt = grg_pkg::glyph_cells(char_code);
          last_nxt  = grg_pkg::glyph_last_cell(char_code);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!hold) begin
          cell_nxt = cell_r + 6'd1;
          if (col_r != grg_pkg::COL_LAST) begin
            x_acc_nxt = sum;
            col_nxt   = col_r + 3'd1;
          end else if (row_r != grg_pkg::ROW_LAST) begin
            x_acc_nxt = cursor_r;
            y_acc_nxt = sum;
            col_nxt   = '0;
            row_nxt   = row_r + 3'd1;
          end else begin
            x_acc_nxt = sum;
            state_nxt = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cursor_nxt = sum;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cursor_r <= '0;
      row_y_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      row_y_r  <= row_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_acc_r <= x_acc_nxt;
    y_acc_r <= y_acc_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    cell_r  <= cell_nxt;
    last_r  <= last_nxt;
    cells_r <= cells_nxt;
  end

endmodule

FILE: tb/sv/glyph_rectangle_generator_core_tb.sv
// Self-checking testbench for the glyph rectangle generator core.
`timescale 1ns / 1ps
module glyph_rectangle_generator_core_tb;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } rect_t;

  class rect_scoreboard;
    rect_t       pending[$];
    logic [7:0]  font_code [11];
    logic [4:0]  font [11][7];
    logic [5:0]  pixel_size;
    logic [7:0]  letter_spacing;
    logic [15:0] cursor_x;
    logic [15:0] line_y;
    int          errors;

    function new();
      font_code = '{"S", "T", "A", "R", "O", "P", "I", "N", "G", "Q", "U"};
      // bit 4 of each row is the leftmost column
      font = '{
        '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}
      };
      pixel_size     = 6'd1;
      letter_spacing = 8'd1;
      cursor_x       = '0;
      line_y         = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic addr, logic [7:0] data);
      if (addr == grg_pkg::REG_PIXEL_SIZE) pixel_size = data[5:0];
      else letter_spacing = data;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Work out the squares of one accepted character.
    function void note_char(logic [7:0] code, logic new_word, logic [15:0] sx, logic [15:0] sy);
      int    g;
      int    found;
      int    drawn;
      rect_t r;
      found = -1;
      drawn = 0;
      if (new_word) begin
        cursor_x = sx;
        line_y   = sy;
      end
      for (g = 0; g < 11; g++)
        if (font_code[g] == code) found = g;
      if (found >= 0) begin
        for (int row = 0; row < grg_pkg::GLYPH_ROWS; row++) begin
          for (int col = 0; col < grg_pkg::GLYPH_COLS; col++) begin
            if (font[found][row][grg_pkg::GLYPH_COLS-1-col]) begin
              r.x    = 16'(cursor_x + col * pixel_size);
              r.y    = 16'(line_y + row * pixel_size);
              r.last = 1'b0;
              pending.push_back(r);
              drawn++;
            end
          end
        end
        if (drawn > 0) pending[pending.size()-1].last = 1'b1;
      end
      cursor_x = 16'(cursor_x + grg_pkg::GLYPH_COLS * pixel_size + letter_spacing);
    endfunction

    function void check_rect(logic [15:0] x, logic [15:0] y, logic last);
      rect_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected square x=%0d y=%0d last=%0b",
                 $time, $signed(x), $signed(y), last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.last !== last) begin
        $display("%0t: square mismatch expected x=%0d y=%0d last=%0b actual x=%0d y=%0d last=%0b",
                 $time, $signed(e.x), $signed(e.y), e.last, $signed(x), $signed(y), last);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // char_code[7:0], start_x[23:8], start_y[39:24]
  logic        in_tuser   = 1'b0; // new_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // rect_x[15:0], rect_y[31:16]
  logic        out_tlast;

  rect_scoreboard sb;
  bit             idling = 1'b1;

  glyph_rectangle_generator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_rect(out_tdata[15:0], out_tdata[31:16], out_tlast);
  end

  // receiver back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_char(logic [7:0] code, logic new_word, logic [15:0] sx, logic [15:0] sy);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sy, sx, code};
    in_tuser  <= new_word;
    do @(posedge clk); while (!in_tready);
    sb.note_char(code, new_word, sx, sy);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    // an unknown character keeps the block busy without producing squares
    repeat (45) @(posedge clk);
  endtask

  // leaves cfg_we high so that writes can follow back to back
  task automatic write_reg(logic addr, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic set_style(logic [7:0] pix, logic [7:0] gap);
    drain();
    write_reg(grg_pkg::REG_PIXEL_SIZE, pix);
    write_reg(grg_pkg::REG_LETTER_SPACING, gap);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF - 16'($urandom_range(0, 300));
      1:       return 16'h8000 + 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_char();
    logic [7:0] code;
    if ($urandom_range(0, 9) < 8) code = sb.font_code[$urandom_range(0, 10)];
    else code = 8'($urandom_range(0, 255));
    send_char(code, $urandom_range(0, 3) == 0, rand_coord(), rand_coord());
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset style: every glyph, extreme positions, unknown codes
    send_char("S", 1'b0, 16'h0000, 16'h0000);
    send_char("T", 1'b1, 16'h7FFF, 16'h7FFF);
    send_char("A", 1'b1, 16'h8000, 16'h8000);
    send_char("R", 1'b0, 16'h0000, 16'h0000);
    send_char("O", 1'b1, 16'hFFFF, 16'hFFFF);
    send_char("P", 1'b0, 16'hFFFF, 16'h0000);
    send_char("I", 1'b0, 16'h0000, 16'hFFFF);
    send_char("N", 1'b1, 16'h0000, 16'h0000);
    send_char("G", 1'b0, 16'h1234, 16'h5678);
    send_char("Q", 1'b0, 16'h0000, 16'h0000);
    send_char("U", 1'b0, 16'h0000, 16'h0000);
    send_char(8'h00, 1'b1, 16'hFFFF, 16'h8000);
    send_char(8'hFF, 1'b0, 16'h0000, 16'h0000);
    send_char("s", 1'b0, 16'h0000, 16'h0000);
    send_char("A", 1'b0, 16'h0000, 16'h0000);

    // zero pixel size squares collapse onto the cursor
    set_style(8'h00, 8'hFF);
    send_char("A", 1'b1, 16'hFFF0, 16'h0010);
    send_char("Q", 1'b0, 16'h0000, 16'h0000);
    send_char("Z", 1'b0, 16'h0000, 16'h0000);
    send_char("N", 1'b0, 16'h0000, 16'h0000);

    // upper data bits dropped: pixel size 63, no spacing, wrap past the top
    set_style(8'hFF, 8'h00);
    send_char("U", 1'b1, 16'h7FF0, 16'h7FC0);
    send_char("G", 1'b0, 16'h0000, 16'h0000);
    send_char("T", 1'b0, 16'h0000, 16'h0000);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_style(8'd1, 8'd0);
        1:       set_style(8'd63, 8'd255);
        2:       set_style(8'd3, 8'd1);
        4:       set_style(8'd2, 8'd7);
        6:       set_style(8'd1, 8'd1);
        default: set_style(8'($urandom_range(1, 63)) | 8'($urandom_range(0, 3) << 6),
                           8'($urandom_range(0, 255)));
      endcase
      if (phase == 7) idling = 1'b0;
      repeat (56) send_random_char();
    end

    drain();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/grg_pkg.sv
rtl/grg_seq.sv
rtl/glyph_rectangle_generator_core.sv
tb/sv/glyph_rectangle_generator_core_tb.sv
